// File: src/mtb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Shared types, opcodes and flag layout for the timer bank cells.
// ----------------------------------------------------------------------------
package mtb_pkg;

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_START   = 4'd1,
    OP_PAUSE   = 4'd2,
    OP_CANCEL  = 4'd3,
    OP_SETDUR  = 4'd4,
    OP_ADD     = 4'd5,
    OP_EN_EV   = 4'd6,
    OP_DIS_EV  = 4'd7,
    OP_QUERY   = 4'd8
  } opcode_t;

  localparam logic [1:0] EV_DONE   = 2'd0;
  localparam logic [1:0] EV_PAUSED = 2'd1;
  localparam logic [1:0] EV_CANCEL = 2'd2;
  localparam logic [1:0] EV_QUERY  = 2'd3;

  // status flag bit positions
  localparam int FL_RUN   = 0;
  localparam int FL_PAUSE = 1;
  localparam int FL_DONE  = 2;
  localparam int FL_CANC  = 3;
  localparam int FL_PREP  = 4;
  localparam int FL_CREP  = 5;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] seg;
    logic [31:0] elapsed;
    logic [5:0]  flags;
    logic [2:0]  en;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647)       return 32'h7fff_ffff;
    else if (x < -34'sd2147483648) return 32'h8000_0000;
    else                           return x[31:0];
  endfunction

endpackage

// File: src/mtb_cell.sv
// ----------------------------------------------------------------------------
// Timer bank cell
// One timer slot; hands its contents to the next cell on each rotation.
// ----------------------------------------------------------------------------
module mtb_cell import mtb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  slot_t d_in,
  output slot_t q
);
  slot_t q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d_in;
    end
  end
  assign q = q_r;
endmodule

// File: src/multi_timer_bank_with_pause_core.sv
// ----------------------------------------------------------------------------
// Timer bank core
// Bank of millisecond countdown timers with pause, cancel and events.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready with opcode, timer_index,
// value and event_select. Results leave on out_valid/out_ready, each with
// event_kind, slot, remaining_ms and last; last marks the final result of a
// request. cfg_we/cfg_wdata write the active count; the user must write it
// only while idle, as the block does not enforce this. Slots live in a ring
// of cells. Every request rotates the ring once, one cell per cycle while no
// slot is held at the head: the slot at the head is updated by a single shared
// update unit and shifted back in at the tail. A slot that yields results stays
// at the head until all of its results are pushed; each result passes through
// a hold register, so its last bit is known, then the output register.
// A tick yields at most 16 results.
// A stalled receiver holds the result in the output register; once the hold
// register is also full, the ring stops at the next slot with results and the
// bank simply waits.
// Tick results come in slot order, paused before canceled before done.
// Reset clears every slot, the active count and all control state.
// ----------------------------------------------------------------------------
module multi_timer_bank_with_pause_core import mtb_pkg::*; #(
  parameter int TIMER_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [2:0]  in_timer_index,
  input  logic signed [31:0] in_value,
  input  logic [1:0]  in_event_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [2:0]  out_slot,
  output logic signed [31:0] out_remaining_ms,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  localparam int CW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int RW = $clog2(TIMER_SLOTS + 1);

  slot_t cell_q [TIMER_SLOTS];
  slot_t head_upd;
  slot_t upd_r;
  slot_t tail_d;
  logic  shift;

  // ring: cell 0 is the head, new contents enter at the tail
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_ring
    slot_t din;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign din = tail_d;
    end else begin : g_mid
      assign din = cell_q[i+1];
    end
    mtb_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d_in(din), .q(cell_q[i]));
  end

  state_t state_r, state_nxt;
  logic [3:0]  act_r;
  logic [RW-1:0] pos_r;
  logic [3:0]  op_r;
  logic [2:0]  idx_r;
  logic [31:0] val_r;
  logic [1:0]  sel_r;
  logic [4:0]  nres_r;            // results emitted so far this request
  // pending results of the head slot
  logic [3:0]  pend_r;            // bit0 paused, bit1 canceled, bit2 done, bit3 query
  logic [31:0] qrem_r;
  // hold register: the newest result, kept until its last bit is known
  logic        hold_v_r;
  logic [1:0]  hold_k_r;
  logic [2:0]  hold_s_r;
  logic [31:0] hold_rem_r;
  // output register
  logic        ov_r;
  logic [1:0]  ok_r;
  logic [2:0]  os_r;
  logic [31:0] orem_r;
  logic        ol_r;

  // ---------------------------------------------------------------- update unit
  slot_t h;
  logic [CW-1:0] hpos;
  logic [3:0]    ev;
  logic [31:0]   rem_c;
  logic signed [33:0] diff;
  logic [7:0]    scan_lim;

  assign h    = cell_q[0];
  assign hpos = pos_r[CW-1:0];
  // the scan covers at most TIMER_SLOTS slots
  assign scan_lim = ({4'd0, act_r} > 8'(TIMER_SLOTS)) ? 8'(TIMER_SLOTS) : {4'd0, act_r};

  always_comb begin
    logic [5:0] f;
    logic in_scan;
    logic signed [33:0] spent;
    logic [31:0] el;
    head_upd = h;
    ev       = '0;
    rem_c    = '0;
    diff     = '0;
    spent    = '0;
    f        = h.flags;
    in_scan  = 1'b0;
    el       = h.elapsed;
    if (op_r == OP_TICK) begin
      // advance every running slot, saturating
      if (h.flags[FL_RUN] && h.elapsed != 32'hffff_ffff) el = h.elapsed + 32'd1;
      head_upd.elapsed = el;
      // stop before a slot that could push this tick past sixteen results
      in_scan = ({{(8-RW){1'b0}}, pos_r} < scan_lim) && (nres_r + 5'd2 <= 5'd16);
      if (in_scan) begin
        if (f[FL_PAUSE] && !f[FL_PREP] && h.en[1]) begin
          ev[0] = 1'b1; f[FL_PREP] = 1'b1;
        end
        if (f[FL_CANC]) begin
          f[FL_RUN] = 1'b0; f[FL_DONE] = 1'b1;
          if (!f[FL_CREP] && h.en[2]) begin
            ev[1] = 1'b1; f[FL_CREP] = 1'b1;
          end
        end
        if (!f[FL_DONE] && !f[FL_CANC]) begin
          if (f[FL_RUN]) diff = {{2{h.seg[31]}}, h.seg} - {2'b00, el};
          else           diff = {{2{h.seg[31]}}, h.seg};
          if (diff <= 0) begin
            f[FL_RUN] = 1'b0; f[FL_DONE] = 1'b1;
            ev[2] = h.en[0];
          end
        end
        head_upd.flags = f;
      end
    end else if ({{(8-CW){1'b0}}, hpos} == {5'd0, idx_r} &&
                 {5'd0, idx_r} < 8'(TIMER_SLOTS)) begin
      case (op_r)
        OP_START: begin
          if (!f[FL_PAUSE]) head_upd.seg = h.total;
          head_upd.elapsed = '0;
          f = '0;
          f[FL_RUN] = 1'b1;
          head_upd.flags = f;
        end
        OP_PAUSE: begin
          if (!f[FL_PAUSE]) begin
            if (f[FL_RUN]) head_upd.seg =
              sat32({{2{h.seg[31]}}, h.seg} - {2'b00, h.elapsed});
            head_upd.elapsed = '0;
            f[FL_PAUSE] = 1'b1; f[FL_RUN] = 1'b0;
            head_upd.flags = f;
          end
        end
        OP_CANCEL: begin
          f[FL_CANC] = 1'b1;
          head_upd.flags = f;
        end
        OP_SETDUR: begin
          head_upd.total = val_r;
          if (f[FL_RUN] && h.total != h.seg) begin
            spent = {{2{h.total[31]}}, h.total} - {{2{h.seg[31]}}, h.seg};
            head_upd.seg = sat32({{2{val_r[31]}}, val_r} - spent);
          end else begin
            head_upd.seg = val_r;
          end
        end
        OP_ADD: head_upd.seg = sat32({{2{h.seg[31]}}, h.seg} + {{2{val_r[31]}}, val_r});
        OP_EN_EV: if (sel_r != 2'd3) head_upd.en = h.en | (3'd1 << sel_r);
        OP_DIS_EV: if (sel_r != 2'd3) head_upd.en = h.en & ~(3'd1 << sel_r);
        OP_QUERY: begin
          ev[3] = 1'b1;
          if (f[FL_RUN]) begin
            diff = {{2{h.seg[31]}}, h.seg} - {2'b00, h.elapsed};
            rem_c = (diff < 0) ? 32'd0 : sat32(diff);
          end else if (f[FL_DONE]) rem_c = '0;
          else rem_c = h.seg;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic [3:0] pick;    // lowest pending result
  logic [3:0] pend_left;
  logic [1:0] pk;
  logic       out_free;
  logic       emit_take;
  logic       push;
  logic       slot_end;
  logic       last_pos;
  logic       accept;
  logic       to_out;

  assign pick      = pend_r & (~pend_r + 4'd1);
  assign pend_left = pend_r & ~pick;
  assign last_pos  = (pos_r == RW'(TIMER_SLOTS - 1));
  assign out_free  = !ov_r || out_ready;
  assign emit_take = !hold_v_r || out_free;

  always_comb begin
    case (pick)
      4'b0001: pk = EV_PAUSED;
      4'b0010: pk = EV_CANCEL;
      4'b0100: pk = EV_DONE;
      default: pk = EV_QUERY;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (|ev)           state_nxt = ST_EMIT;
        else if (last_pos) state_nxt = ST_FLUSH;
      end
      ST_EMIT: if (slot_end) state_nxt = last_pos ? ST_FLUSH : ST_SCAN;
      ST_FLUSH: if (!hold_v_r || out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold the head until its results have gone, then rotate
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;
    push     = (state_r == ST_EMIT) && emit_take;
    slot_end = push && (pend_left == 4'd0);
    shift    = ((state_r == ST_SCAN) && !(|ev)) || slot_end;
    tail_d   = (state_r == ST_EMIT) ? upd_r : head_upd;
    // the held result leaves when a newer one arrives or the request ends
    to_out   = hold_v_r && (push || ((state_r == ST_FLUSH) && out_free));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      act_r    <= '0;
      pos_r    <= '0;
      nres_r   <= '0;
      pend_r   <= '0;
      ov_r     <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) act_r <= cfg_wdata;
      if (accept)     pos_r <= '0;
      else if (shift) pos_r <= pos_r + RW'(1);
      if (accept)    nres_r <= '0;
      else if (push) nres_r <= nres_r + 5'd1;
      if (state_r == ST_SCAN && |ev) pend_r <= ev;
      else if (push)                 pend_r <= pend_left;
      if (to_out)         ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (push)        hold_v_r <= 1'b1;
      else if (to_out) hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode; idx_r <= in_timer_index; val_r <= in_value; sel_r <= in_event_select;
    end
    // freeze the updated head while its results drain
    if (state_r == ST_SCAN && |ev) begin
      upd_r  <= head_upd;
      qrem_r <= rem_c;
    end
    if (to_out) begin
      ok_r <= hold_k_r; os_r <= hold_s_r; orem_r <= hold_rem_r; ol_r <= (state_r == ST_FLUSH);
    end
    if (push) begin
      hold_k_r <= pk; hold_s_r <= 3'(hpos);
      hold_rem_r <= (pk == EV_QUERY) ? qrem_r : 32'd0;
    end
  end

  assign out_valid        = ov_r;
  assign out_event_kind   = ok_r;
  assign out_slot         = os_r;
  assign out_remaining_ms = orem_r;
  assign out_last         = ol_r;

  property p_ring_still_when_stalled;
    @(posedge clk) disable iff (!rst_n)
      (ov_r && !out_ready && hold_v_r && state_r == ST_EMIT) |-> !shift;
  endproperty
  assert property (p_ring_still_when_stalled) else $error("ring moved while output stalled");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_IDLE) |-> !in_ready;
  endproperty
  assert property (p_no_accept_busy) else $error("request accepted while busy");

  property p_cap;
    @(posedge clk) disable iff (!rst_n) nres_r <= 5'd16;
  endproperty
  assert property (p_cap) else $error("result count exceeded cap");

  property p_out_held;
    @(posedge clk) disable iff (!rst_n)
      (ov_r && !out_ready) |=> (ov_r && $stable(orem_r) && $stable(ol_r));
  endproperty
  assert property (p_out_held) else $error("result changed while stalled");

  property p_idle_hold_empty;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_IDLE) |-> !hold_v_r;
  endproperty
  assert property (p_idle_hold_empty) else $error("hold register full while idle");
endmodule
